// ===== rtl/tcoq_pkg.sv =====
package tcoq_pkg;

    localparam int ID_BITS            = 16;
    localparam int QUEUE_DEPTH_DEF    = 16;
    localparam int STAMP_BITS_DEF     = 32;

    localparam logic [2:0] CMD_ADD_A    = 3'd0;
    localparam logic [2:0] CMD_ADD_B    = 3'd1;
    localparam logic [2:0] CMD_TAKE_A   = 3'd2;
    localparam logic [2:0] CMD_TAKE_B   = 3'd3;
    localparam logic [2:0] CMD_TAKE_ANY = 3'd4;

    localparam logic [1:0] ST_TAKEN = 2'd0;
    localparam logic [1:0] ST_ADDED = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic CLASS_A = 1'b0;
    localparam logic CLASS_B = 1'b1;

    typedef struct packed {
        logic [2:0]         command;
        logic [ID_BITS-1:0] item_id;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_BITS-1:0] taken_id;
        logic               taken_class;
    } t_out_word;

endpackage

// ===== rtl/tcoq_fifo.sv =====
module tcoq_fifo
    import tcoq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int DW    = STAMP_BITS_DEF + ID_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_pop,
    input  logic [DW-1:0] i_push_data,
    output logic          o_empty,
    output logic          o_full,
    output logic [DW-1:0] o_head_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_head_data;
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_head;
    logic [AW-1:0] n_tail;
    logic [CW-1:0] n_count;

    assign o_empty     = (r_count == '0);
    assign o_full      = (r_count == FULL_COUNT);
    assign o_head_data = r_head_data;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_pop) begin
            n_head = (r_head == LAST) ? '0 : r_head + AW'(1);
        end
        if (i_push) begin
            n_tail = (r_tail == LAST) ? '0 : r_tail + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // prefetch the next head entry, forward a write to the same slot
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_push_data;
        end
        if (i_push && (r_tail == n_head)) begin
            r_head_data <= i_push_data;
        end else begin
            r_head_data <= r_mem[n_head];
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("fifo count above depth");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty fifo");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> !o_full)
        else $error("push into full fifo");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty || o_full) |-> (r_head == r_tail))
        else $error("pointers disagree with count");
`endif

endmodule

// ===== rtl/two_class_oldest_first_queue_unit.sv =====
// channel | valid      | stall       | word
// input   | i_in_valid | o_in_stall  | i_in  (command, item_id)
// output  | o_out_valid| i_out_stall | o_out (status, taken_id, taken_class)
//
// One word accepted per cycle while o_in_stall is low.
// Each word passes an input register, one pass over the queue heads, and a result register.
// Queue heads are prefetched from each store into a head register, with write forwarding.
// Synchronous active-low reset clears pointers, counts and the arrival counter.
// A stalled output holds the result register; the input stalls only when both registers are full.
module two_class_oldest_first_queue_unit
    import tcoq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int STAMP_BITS  = STAMP_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out
);

    localparam int DW = STAMP_BITS + ID_BITS;

    logic                  r_in_valid;
    t_in_word              r_in;
    logic                  r_out_valid;
    t_out_word             r_out;
    logic [STAMP_BITS-1:0] r_arrival;

    logic                  proc_fire;
    logic                  push_a;
    logic                  push_b;
    logic                  pop_a;
    logic                  pop_b;
    logic                  a_empty;
    logic                  a_full;
    logic                  b_empty;
    logic                  b_full;
    logic [DW-1:0]         a_head;
    logic [DW-1:0]         b_head;
    logic [DW-1:0]         push_data;
    logic [STAMP_BITS-1:0] n_arrival;
    logic [STAMP_BITS-1:0] stamp_diff;
    logic                  a_older;
    logic                  add_a;
    logic                  add_b;
    logic                  take_a;
    logic                  take_b;
    t_out_word             n_out;

    assign proc_fire   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !proc_fire;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign n_arrival  = r_arrival + STAMP_BITS'(1);
    assign push_data  = {n_arrival, r_in.item_id};
    assign stamp_diff = b_head[DW-1:ID_BITS] - a_head[DW-1:ID_BITS];
    assign a_older    = !stamp_diff[STAMP_BITS-1];

    always_comb begin
        add_a  = 1'b0;
        add_b  = 1'b0;
        take_a = 1'b0;
        take_b = 1'b0;
        n_out  = '{status: ST_NONE, taken_id: '0, taken_class: CLASS_A};
        unique case (r_in.command)
            CMD_ADD_A: begin
                add_a        = !a_full;
                n_out.status = a_full ? ST_FULL : ST_ADDED;
            end
            CMD_ADD_B: begin
                add_b        = !b_full;
                n_out.status = b_full ? ST_FULL : ST_ADDED;
            end
            CMD_TAKE_A: begin
                take_a = !a_empty;
            end
            CMD_TAKE_B: begin
                take_b = !b_empty;
            end
            CMD_TAKE_ANY: begin
                priority if (a_empty) begin
                    take_b = !b_empty;
                end else if (b_empty) begin
                    take_a = 1'b1;
                end else begin
                    take_a = a_older;
                    take_b = !a_older;
                end
            end
            default: begin
            end
        endcase
        if (take_a) begin
            n_out = '{status: ST_TAKEN, taken_id: a_head[ID_BITS-1:0], taken_class: CLASS_A};
        end else if (take_b) begin
            n_out = '{status: ST_TAKEN, taken_id: b_head[ID_BITS-1:0], taken_class: CLASS_B};
        end
    end

    assign push_a = proc_fire && add_a;
    assign push_b = proc_fire && add_b;
    assign pop_a  = proc_fire && take_a;
    assign pop_b  = proc_fire && take_b;

    tcoq_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .DW    (DW)
    ) u_fifo_a (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push_a),
        .i_pop       (pop_a),
        .i_push_data (push_data),
        .o_empty     (a_empty),
        .o_full      (a_full),
        .o_head_data (a_head)
    );

    tcoq_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .DW    (DW)
    ) u_fifo_b (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push_b),
        .i_pop       (pop_b),
        .i_push_data (push_data),
        .o_empty     (b_empty),
        .o_full      (b_full),
        .o_head_data (b_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_arrival   <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (proc_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (push_a || push_b) begin
                r_arrival <= n_arrival;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
        if (proc_fire) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTH
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({push_a, push_b, pop_a, pop_b}) <= 1)
        else $error("more than one queue action per word");
    a_arrival_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push_a || push_b) |=> $stable(r_arrival))
        else $error("arrival counter moved without an add");
    a_take_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire |=> ((r_out.status == ST_TAKEN) == ($past(pop_a) || $past(pop_b))))
        else $error("taken status disagrees with queue pop");
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a held word");
`endif

endmodule
